>>> hdl/text_stream_statistics_unit_assert.svh
// Assertion macros shared by the checker of the text stream statistics unit.
// Depends on nothing; included by the checker file only.
`ifndef TEXT_STREAM_STATISTICS_UNIT_ASSERT_SVH
`define TEXT_STREAM_STATISTICS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TSSU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text stream statistics check failed");

// Next-cycle implication, disabled while reset is high.
`define TSSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text stream statistics check failed");

`endif

>>> hdl/tssu_pkg.sv
// Shared types, constants and helpers of the text stream statistics unit.
// No dependencies; imported by every module of the block.
package tssu_pkg;

   localparam int CNT_W      = 32;   // width of every statistics counter
   localparam int OUT_W      = 32;   // width of the count fields on the result port
   localparam int BYTE_W     = 8;
   localparam int HIST_DEPTH = 1 << BYTE_W;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] FUNC_DATA   = 2'd0;
   localparam logic [1:0] FUNC_REPORT = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   localparam logic [BYTE_W-1:0] NL_BYTE    = 8'h0A;
   localparam logic [BYTE_W-1:0] TAB_BYTE   = 8'h09;
   localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0D;
   localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_REPORT,
      OP_READ
   } op_type;

   // One classified word as it travels from the front end to the back end.
   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   value;
      logic                blank;
      logic                newline;
   } item_type;

   // Payload of one result word.
   typedef struct packed {
      logic [OUT_W-1:0] char_count;
      logic [OUT_W-1:0] word_count;
      logic [OUT_W-1:0] line_count;
      logic [OUT_W-1:0] longest_line;
      logic             overflow;
      logic [OUT_W-1:0] bin_count;
   } result_type;

   // Whitespace is the space character and the codes from tab to carriage return.
   function automatic logic is_blank(input logic [BYTE_W-1:0] b);
      return (b == SPACE_BYTE) || (b inside {[TAB_BYTE:CR_BYTE]});
   endfunction

endpackage

>>> hdl/tssu_front.sv
// Front end of the text stream statistics unit: accepts request words and classifies them.
// Depends on tssu_pkg.
module tssu_front
   import tssu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [BYTE_W-1:0] req_value,
   input  logic              q_full,
   output logic              q_push,
   output item_type          q_item
);

   logic     front_valid_ff;
   logic     front_valid_in;
   item_type front_item_ff;
   item_type front_item_in;
   logic     accept;
   logic     known_func;

   assign req_stall = front_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = front_valid_ff && !q_full;
   assign q_item    = front_item_ff;

   always_comb begin
      known_func            = 1'b1;
      front_item_in.op      = OP_BYTE;
      front_item_in.value   = req_value;
      front_item_in.blank   = is_blank(req_value);
      front_item_in.newline = (req_value == NL_BYTE);
      case (req_func)
         FUNC_DATA:   front_item_in.op = OP_BYTE;
         FUNC_REPORT: front_item_in.op = OP_REPORT;
         FUNC_READ:   front_item_in.op = OP_READ;
         default:     known_func = 1'b0;   // the unused selector is dropped here
      endcase
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = known_func;
      end else if (q_push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

endmodule

>>> hdl/tssu_fifo.sv
// Short queue that decouples the front end from the back end.
// Depends on tssu_pkg.
module tssu_fifo
   import tssu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head_item
);

   item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = Q_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = Q_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/tssu_back.sv
// Back end of the text stream statistics unit: counters, byte histogram and result register.
// Depends on tssu_pkg.
module tssu_back
   import tssu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       count_words,
   input  logic       q_empty,
   input  item_type   q_item,
   output logic       q_pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_data
);

   // Execute stage: the word popped from the queue plus the histogram entry read for it.
   logic                  b_valid_ff;
   logic                  b_valid_in;
   item_type              b_item_ff;
   logic [CNT_W-1:0]      rd_data_ff;

   logic [CNT_W-1:0]      hist_mem [HIST_DEPTH];
   logic [HIST_DEPTH-1:0] hist_valid_ff;
   logic [HIST_DEPTH-1:0] hist_valid_in;

   // Last histogram write, forwarded to a read that was issued in the same cycle.
   logic                  fwd_en_ff;
   logic                  fwd_en_in;
   logic [BYTE_W-1:0]     fwd_addr_ff;
   logic [CNT_W-1:0]      fwd_data_ff;

   logic [CNT_W-1:0]      bytes_ff,    bytes_in;
   logic [CNT_W-1:0]      words_ff,    words_in;
   logic [CNT_W-1:0]      lines_ff,    lines_in;
   logic [CNT_W-1:0]      max_len_ff,  max_len_in;
   logic [CNT_W-1:0]      cur_len_ff,  cur_len_in;
   logic                  after_space_ff, after_space_in;
   logic                  saturated_ff,   saturated_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff;
   result_type            result;

   logic                  has_result;
   logic                  retire;
   logic                  take;
   logic                  at_limit;
   logic                  count_byte;
   logic                  is_report;
   logic [CNT_W-1:0]      hist_cur;
   logic [CNT_W-1:0]      hist_inc;
   logic [CNT_W-1:0]      len_inc;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      has_result = b_valid_ff && (b_item_ff.op != OP_BYTE);
      retire     = b_valid_ff && (!has_result || !rsp_valid_ff || !rsp_stall);
      q_pop      = !q_empty && (!b_valid_ff || retire);
      is_report  = retire && (b_item_ff.op == OP_REPORT);
      take       = retire && (b_item_ff.op == OP_BYTE) && !saturated_ff;
      at_limit   = (bytes_ff == {CNT_W{1'b1}});
      count_byte = take && !at_limit;
      if (fwd_en_ff && (fwd_addr_ff == b_item_ff.value)) begin
         hist_cur = fwd_data_ff;
      end else if (hist_valid_ff[b_item_ff.value]) begin
         hist_cur = rd_data_ff;
      end else begin
         hist_cur = '0;
      end
      hist_inc = CNT_W'(hist_cur + 1'b1);
      len_inc  = CNT_W'(cur_len_ff + 1'b1);
   end

   always_comb begin
      bytes_in       = bytes_ff;
      words_in       = words_ff;
      lines_in       = lines_ff;
      max_len_in     = max_len_ff;
      cur_len_in     = cur_len_ff;
      after_space_in = after_space_ff;
      saturated_in   = saturated_ff;
      hist_valid_in  = hist_valid_ff;
      fwd_en_in      = fwd_en_ff;

      if (take && at_limit) begin
         saturated_in = 1'b1;
      end
      if (count_byte) begin
         bytes_in  = CNT_W'(bytes_ff + 1'b1);
         fwd_en_in = 1'b1;
         hist_valid_in[b_item_ff.value] = 1'b1;
         if (b_item_ff.newline) begin
            lines_in   = CNT_W'(lines_ff + 1'b1);
            cur_len_in = '0;
            if (len_inc > max_len_ff) begin
               max_len_in = len_inc;
            end
         end else begin
            cur_len_in = len_inc;
         end
         if (count_words) begin
            if (b_item_ff.blank) begin
               after_space_in = 1'b1;
            end else if (after_space_ff) begin
               after_space_in = 1'b0;
               words_in       = CNT_W'(words_ff + 1'b1);
            end
         end
      end
      if (is_report) begin
         bytes_in       = '0;
         words_in       = '0;
         lines_in       = '0;
         cur_len_in     = '0;
         after_space_in = 1'b1;
         hist_valid_in  = '0;
         fwd_en_in      = 1'b0;
      end
   end

   always_comb begin
      result = '0;
      if (b_item_ff.op == OP_REPORT) begin
         result.char_count   = OUT_W'(bytes_ff);
         result.word_count   = OUT_W'(words_ff);
         result.line_count   = OUT_W'(lines_ff);
         result.longest_line = OUT_W'(max_len_ff);
         result.overflow     = saturated_ff;
      end else begin
         result.bin_count = OUT_W'(hist_cur);
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (q_pop) begin
         b_valid_in = 1'b1;
      end else if (retire) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (retire && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff     <= 1'b0;
         bytes_ff       <= '0;
         words_ff       <= '0;
         lines_ff       <= '0;
         max_len_ff     <= '0;
         cur_len_ff     <= '0;
         after_space_ff <= 1'b1;
         saturated_ff   <= 1'b0;
         hist_valid_ff  <= '0;
         fwd_en_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         b_valid_ff     <= b_valid_in;
         bytes_ff       <= bytes_in;
         words_ff       <= words_in;
         lines_ff       <= lines_in;
         max_len_ff     <= max_len_in;
         cur_len_ff     <= cur_len_in;
         after_space_ff <= after_space_in;
         saturated_ff   <= saturated_in;
         hist_valid_ff  <= hist_valid_in;
         fwd_en_ff      <= fwd_en_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff  <= q_item;
         rd_data_ff <= hist_mem[q_item.value];
      end
      if (count_byte) begin
         hist_mem[b_item_ff.value] <= hist_inc;
         fwd_addr_ff               <= b_item_ff.value;
         fwd_data_ff               <= hist_inc;
      end
      if (retire && has_result) begin
         rsp_data_ff <= result;
      end
   end

endmodule

>>> hdl/text_stream_statistics_unit.sv
// Top level of the text stream statistics unit: front end, queue and back end.
// Depends on tssu_pkg, tssu_front, tssu_fifo and tssu_back.
//
// The request channel carries one word per handshake: req_func selects a data byte,
// a report that also clears the per-file counts, or a histogram bin read, and req_value
// holds the byte or the bin index. A word is taken when req_valid is high and req_stall
// is low. Data bytes and the unused selector give no result; a report or a bin read
// gives exactly one result word on the rsp_ channel, in request order.
// A new word is accepted every cycle while req_stall is low. A result passes through
// the front register, the queue, the execute stage, which also holds the histogram
// memory read, and the result register.
// When rsp_stall holds a result, the back end keeps executing data bytes and stops only
// at the next word that needs the result register; the four-entry queue then fills and
// req_stall rises. Histogram updates run at one per cycle: the last write is forwarded
// to a read of the same bin issued in the same cycle.
// csr_write_enable writes csr_write_data into the word counting enable; the user must
// write it only while the unit is idle (not enforced). Reset clears all counters, the
// histogram (through one valid bit per bin), the queue and rsp_valid, and disables word
// counting. The longest line and overflow flag survive reports and clear only at reset.
module text_stream_statistics_unit
   import tssu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [BYTE_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [OUT_W-1:0]  rsp_char_count,
   output logic [OUT_W-1:0]  rsp_word_count,
   output logic [OUT_W-1:0]  rsp_line_count,
   output logic [OUT_W-1:0]  rsp_longest_line,
   output logic              rsp_overflow,
   output logic [OUT_W-1:0]  rsp_bin_count,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   // Word counting enable; the only configuration register.
   logic       count_words_ff;
   logic       count_words_in;

   logic       q_push;
   logic       q_pop;
   logic       q_full;
   logic       q_empty;
   item_type   q_in_item;
   item_type   q_head_item;
   result_type rsp_data;

   assign count_words_in = csr_write_enable ? csr_write_data : count_words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_words_ff <= 1'b0;
      end else begin
         count_words_ff <= count_words_in;
      end
   end

   // The front end registers and classifies each request word.
   tssu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   // The queue lets the front end keep taking words while the result side is held.
   tssu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head_item)
   );

   // The back end owns every statistics counter, the histogram and the result register.
   tssu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .count_words (count_words_ff),
      .q_empty     (q_empty),
      .q_item      (q_head_item),
      .q_pop       (q_pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign rsp_char_count   = rsp_data.char_count;
   assign rsp_word_count   = rsp_data.word_count;
   assign rsp_line_count   = rsp_data.line_count;
   assign rsp_longest_line = rsp_data.longest_line;
   assign rsp_overflow     = rsp_data.overflow;
   assign rsp_bin_count    = rsp_data.bin_count;

endmodule

>>> hdl/tssu_checker.sv
// Port-level checker of the text stream statistics unit and its bind to the top level.
// Depends on tssu_pkg and text_stream_statistics_unit_assert.svh.
`include "text_stream_statistics_unit_assert.svh"

module tssu_checker
   import tssu_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_func,
   input logic [BYTE_W-1:0] req_value,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [OUT_W-1:0]  rsp_char_count,
   input logic [OUT_W-1:0]  rsp_word_count,
   input logic [OUT_W-1:0]  rsp_line_count,
   input logic [OUT_W-1:0]  rsp_longest_line,
   input logic              rsp_overflow,
   input logic [OUT_W-1:0]  rsp_bin_count
);

   // Whole payloads side by side, so that one check covers every field.
   logic [5*OUT_W:0]   rsp_payload;
   logic [BYTE_W+1:0]  req_payload;
   logic               report_fields_zero;
   logic               counts_ordered;

   assign rsp_payload = {rsp_char_count, rsp_word_count, rsp_line_count, rsp_longest_line,
                         rsp_overflow, rsp_bin_count};
   assign req_payload = {req_func, req_value};
   assign report_fields_zero = (rsp_char_count == '0) && (rsp_word_count == '0) &&
                               (rsp_line_count == '0) && (rsp_longest_line == '0) &&
                               !rsp_overflow;
   assign counts_ordered = (rsp_word_count <= rsp_char_count) &&
                           (rsp_line_count <= rsp_char_count);

   // A held result keeps its valid and its payload.
   `TSSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // A held request word keeps its valid and its payload.
   `TSSU_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_payload))

   // A bin read result carries nothing but the bin count.
   `TSSU_ASSERT_SAME(a_bin_only, clock, reset, rsp_valid && (rsp_bin_count != '0), report_fields_zero)

   // Every counted word and every counted newline is also a counted byte.
   `TSSU_ASSERT_SAME(a_counts_bounded, clock, reset, rsp_valid, counts_ordered)

   // No result is pending right after reset.
   `TSSU_ASSERT_SAME(a_reset_empty, clock, reset, $fell(reset), !rsp_valid)

endmodule

bind text_stream_statistics_unit tssu_checker u_checker (.*);
